// File: rtl/dsv_pkg.sv
// ----------------------------------------------------------------------------
// Date string validator package
// Shared constants, status codes and the text state record that the
// validator and its judging logic exchange.
// ----------------------------------------------------------------------------
package dsv_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned DAY_W   = 7;
    localparam int unsigned MONTH_W = 7;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [POS_W-1:0] DATE_LEN    = 4'd10;
    localparam logic [POS_W-1:0] SEP_POS_A   = 4'd2;
    localparam logic [POS_W-1:0] SEP_POS_B   = 4'd5;
    localparam logic [POS_W-1:0] YEAR_POS    = 4'd6;
    localparam logic [POS_W-1:0] CENT_LO_POS = 4'd7;
    localparam logic [POS_W-1:0] LOW_HI_POS  = 4'd8;

    localparam logic [CHAR_W-1:0] SEP_CHAR   = 8'h2F;
    localparam logic [CHAR_W-1:0] DIGIT_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] DIGIT_NINE = 8'h39;

    localparam logic [YEAR_W-1:0] EARLIEST_YEAR_RST = 14'd1900;
    localparam logic [YEAR_W-1:0] LATEST_YEAR_RST   = 14'd2099;

    localparam logic [CFG_IDX_W-1:0] REG_EARLIEST_YEAR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LATEST_YEAR   = 1'b1;

    typedef enum logic [3:0] {
        STATUS_OK          = 4'd0,
        STATUS_BAD_FORMAT  = 4'd1,
        STATUS_DAY_CHAR    = 4'd2,
        STATUS_MONTH_CHAR  = 4'd3,
        STATUS_YEAR_CHAR   = 4'd4,
        STATUS_DAY_LIMIT   = 4'd5,
        STATUS_MONTH_RANGE = 4'd6,
        STATUS_DAY_RANGE   = 4'd7,
        STATUS_YEAR_BOUND  = 4'd8
    } t_status;

    // Text state after the current character has been folded in. The
    // century and low year digit pairs are kept modulo four for the leap rule.
    typedef struct packed {
        logic [POS_W-1:0]   pos;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic               sep_bad;
        logic               day_bad;
        logic               month_bad;
        logic               year_bad;
        logic [1:0]         cent_m4;
        logic [1:0]         low_m4;
        logic               low_zero;
    } t_text;

endpackage

// File: rtl/dsv_judge.sv
// ----------------------------------------------------------------------------
// Date judge
// Turns a complete text state into a status code, applying format,
// calendar and year bound checks in priority order.
// ----------------------------------------------------------------------------
module dsv_judge
    import dsv_pkg::*;
(
    input  t_text               i_text,
    input  logic [YEAR_W-1:0]   i_earliest_year,
    input  logic [YEAR_W-1:0]   i_latest_year,
    output t_status             o_status
);

    logic leap;
    logic short_month;
    logic is_feb;

    assign leap = (i_text.low_m4 == 2'd0) && (!i_text.low_zero || (i_text.cent_m4 == 2'd0));
    assign is_feb = (i_text.month == 7'd2);
    assign short_month = (i_text.month == 7'd4) || (i_text.month == 7'd6) ||
                         (i_text.month == 7'd9) || (i_text.month == 7'd11);

    always_comb begin
        if ((i_text.pos != DATE_LEN) || i_text.sep_bad) begin
            o_status = STATUS_BAD_FORMAT;
        end else if (i_text.day_bad) begin
            o_status = STATUS_DAY_CHAR;
        end else if (i_text.month_bad) begin
            o_status = STATUS_MONTH_CHAR;
        end else if (i_text.year_bad) begin
            o_status = STATUS_YEAR_CHAR;
        end else if (is_feb && (i_text.day > 7'd29)) begin
            o_status = STATUS_DAY_LIMIT;
        end else if ((i_text.month == 7'd0) || (i_text.month > 7'd12)) begin
            o_status = STATUS_MONTH_RANGE;
        end else if ((i_text.day == 7'd0) || (i_text.day > 7'd31)) begin
            o_status = STATUS_DAY_RANGE;
        end else if (short_month && (i_text.day > 7'd30)) begin
            o_status = STATUS_DAY_LIMIT;
        end else if (!leap && is_feb && (i_text.day > 7'd28)) begin
            o_status = STATUS_DAY_LIMIT;
        end else if ((i_text.year < i_earliest_year) || (i_text.year > i_latest_year)) begin
            o_status = STATUS_YEAR_BOUND;
        end else begin
            o_status = STATUS_OK;
        end
    end

endmodule

// File: rtl/date_string_validator.sv
// ----------------------------------------------------------------------------
// Date string validator
// Checks a DD/MM/YYYY text that arrives one character per transaction and
// reports a status code with the parsed day, month and year on the final one.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  input     in         i_in_valid / o_in_stall   i_char_code, i_final_char
//  output    out        o_out_valid / i_out_stall o_status, o_*_value
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One character is accepted every cycle unless a final character is held by
// o_in_stall. A character is registered on input and then folded into the
// text state; the final character also loads the result register at that
// edge. Only final characters wait on a stalled result register. Reset
// restores the year bounds to 1900 and 2099 and clears the text state.
// ----------------------------------------------------------------------------
module date_string_validator
    import dsv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [CHAR_W-1:0]    i_char_code,
    input  logic                 i_final_char,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [3:0]           o_status,
    output logic [DAY_W-1:0]     o_day_value,
    output logic [MONTH_W-1:0]   o_month_value,
    output logic [YEAR_W-1:0]    o_year_value,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [YEAR_W-1:0]    i_cfg_data
);

    logic [YEAR_W-1:0]  r_earliest_year;
    logic [YEAR_W-1:0]  r_latest_year;

    logic               r_in_valid;
    logic [CHAR_W-1:0]  r_char;
    logic               r_final;

    t_text              r_text;
    t_text              n_text;

    logic               r_out_valid;
    t_status            r_status;
    logic [DAY_W-1:0]   r_day;
    logic [MONTH_W-1:0] r_month;
    logic [YEAR_W-1:0]  r_year;

    logic               out_free;
    logic               fire;
    logic               is_digit;
    logic [3:0]         digit;
    t_status            status;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && (!r_final || out_free);
    assign o_in_stall = r_in_valid && !fire;
    assign o_cfg_ready = 1'b1;

    assign is_digit = (r_char >= DIGIT_ZERO) && (r_char <= DIGIT_NINE);
    assign digit    = is_digit ? r_char[3:0] : 4'd0;

    always_comb begin
        n_text = r_text;
        if (r_text.pos < DATE_LEN) begin
            if ((r_text.pos == SEP_POS_A) || (r_text.pos == SEP_POS_B)) begin
                if (r_char != SEP_CHAR) begin
                    n_text.sep_bad = 1'b1;
                end
            end else if (r_text.pos < SEP_POS_A) begin
                n_text.day_bad = r_text.day_bad || !is_digit;
                n_text.day = DAY_W'(r_text.day * 7'd10 + DAY_W'(digit));
            end else if (r_text.pos < SEP_POS_B) begin
                n_text.month_bad = r_text.month_bad || !is_digit;
                n_text.month = MONTH_W'(r_text.month * 7'd10 + MONTH_W'(digit));
            end else begin
                n_text.year_bad = r_text.year_bad || !is_digit;
                n_text.year = YEAR_W'(r_text.year * 14'd10 + YEAR_W'(digit));
                if (r_text.pos == YEAR_POS) begin
                    n_text.cent_m4 = digit[1:0];
                end else if (r_text.pos == CENT_LO_POS) begin
                    n_text.cent_m4 = 2'({r_text.cent_m4[0], 1'b0} + digit[1:0]);
                end else if (r_text.pos == LOW_HI_POS) begin
                    n_text.low_m4   = digit[1:0];
                    n_text.low_zero = (digit == 4'd0);
                end else begin
                    n_text.low_m4   = 2'({r_text.low_m4[0], 1'b0} + digit[1:0]);
                    n_text.low_zero = r_text.low_zero && (digit == 4'd0);
                end
            end
            n_text.pos = r_text.pos + 4'd1;
        end
    end

    dsv_judge u_judge (
        .i_text          (n_text),
        .i_earliest_year (r_earliest_year),
        .i_latest_year   (r_latest_year),
        .o_status        (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_earliest_year <= EARLIEST_YEAR_RST;
            r_latest_year   <= LATEST_YEAR_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_EARLIEST_YEAR) begin
                r_earliest_year <= i_cfg_data;
            end else begin
                r_latest_year <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!r_in_valid || fire) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_char  <= i_char_code;
            r_final <= i_final_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text <= '0;
        end else if (fire) begin
            if (r_final) begin
                r_text <= '0;
            end else begin
                r_text <= n_text;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && r_final) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_final) begin
            r_status <= status;
            r_day    <= n_text.day;
            r_month  <= n_text.month;
            r_year   <= n_text.year;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_day_value   = r_day;
    assign o_month_value = r_month;
    assign o_year_value  = r_year;

endmodule

// File: tb/dsv_checker.sv
// ----------------------------------------------------------------------------
// Date string validator checker
// Watches the character, result and register channels of the validator. It
// keeps its own copy of the text state and the year bounds, and works out
// the status and parsed values for each final character. Each result
// transaction is compared with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module dsv_checker
    import dsv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [CHAR_W-1:0]    i_char_code,
    input  logic                 i_final_char,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [3:0]           i_status,
    input  logic [DAY_W-1:0]     i_day_value,
    input  logic [MONTH_W-1:0]   i_month_value,
    input  logic [YEAR_W-1:0]    i_year_value,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [YEAR_W-1:0]    i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        t_status            status;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } t_date_result;

    t_date_result       verdicts_due[$];
    t_date_result       due;
    int                 mismatches = 0;

    logic [POS_W-1:0]   pos;
    logic [DAY_W-1:0]   day_acc;
    logic [MONTH_W-1:0] month_acc;
    logic [YEAR_W-1:0]  year_acc;
    logic               sep_err;
    logic               day_err;
    logic               month_err;
    logic               year_err;
    logic [YEAR_W-1:0]  low_bound;
    logic [YEAR_W-1:0]  high_bound;

    assign o_fail_count = mismatches;

    function automatic t_status judge_date(input int d, input int m, input int y);
        bit leap;
        if (pos != DATE_LEN || sep_err) return STATUS_BAD_FORMAT;
        if (day_err) return STATUS_DAY_CHAR;
        if (month_err) return STATUS_MONTH_CHAR;
        if (year_err) return STATUS_YEAR_CHAR;
        if (m == 2 && d > 29) return STATUS_DAY_LIMIT;
        if (m == 0 || m > 12) return STATUS_MONTH_RANGE;
        if (d == 0 || d > 31) return STATUS_DAY_RANGE;
        if ((m == 4 || m == 6 || m == 9 || m == 11) && d > 30) return STATUS_DAY_LIMIT;
        leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        if (!leap && m == 2 && d > 28) return STATUS_DAY_LIMIT;
        if (y < int'(low_bound) || y > int'(high_bound)) return STATUS_YEAR_BOUND;
        return STATUS_OK;
    endfunction

    task automatic clear_text();
        pos = '0;
        day_acc = '0;
        month_acc = '0;
        year_acc = '0;
        sep_err = 1'b0;
        day_err = 1'b0;
        month_err = 1'b0;
        year_err = 1'b0;
    endtask

    task automatic fold_char(input logic [CHAR_W-1:0] c, input logic fin);
        bit           is_digit;
        int           digit;
        t_date_result res;
        is_digit = (c >= DIGIT_ZERO) && (c <= DIGIT_NINE);
        digit = is_digit ? int'(c - DIGIT_ZERO) : 0;
        if (pos < DATE_LEN) begin
            if (pos == SEP_POS_A || pos == SEP_POS_B) begin
                if (c != SEP_CHAR) sep_err = 1'b1;
            end else if (pos < SEP_POS_A) begin
                if (!is_digit) day_err = 1'b1;
                day_acc = DAY_W'(int'(day_acc) * 10 + digit);
            end else if (pos < SEP_POS_B) begin
                if (!is_digit) month_err = 1'b1;
                month_acc = MONTH_W'(int'(month_acc) * 10 + digit);
            end else begin
                if (!is_digit) year_err = 1'b1;
                year_acc = YEAR_W'(int'(year_acc) * 10 + digit);
            end
            pos = pos + 1'b1;
        end
        if (fin) begin
            res.status = judge_date(int'(day_acc), int'(month_acc), int'(year_acc));
            res.day = day_acc;
            res.month = month_acc;
            res.year = year_acc;
            verdicts_due.push_back(res);
            clear_text();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_text();
            low_bound = EARLIEST_YEAR_RST;
            high_bound = LATEST_YEAR_RST;
            verdicts_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_EARLIEST_YEAR) low_bound = i_cfg_data;
                else high_bound = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (verdicts_due.size() == 0) begin
                    $display("%0t: unexpected result: status %0d day %0d month %0d year %0d",
                             $time, i_status, i_day_value, i_month_value, i_year_value);
                    mismatches++;
                end else begin
                    due = verdicts_due.pop_front();
                    if (i_status !== due.status || i_day_value !== due.day ||
                        i_month_value !== due.month || i_year_value !== due.year) begin
                        $display("%0t: expected status %0d day %0d month %0d year %0d, %s",
                                 $time, due.status, due.day, due.month, due.year,
                                 $sformatf("got status %0d day %0d month %0d year %0d",
                                           i_status, i_day_value, i_month_value,
                                           i_year_value));
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) fold_char(i_char_code, i_final_char);
        end
        o_pending <= verdicts_due.size();
    end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Date string validator testbench
// Sends DD/MM/YYYY texts one character per transaction: a short directed set
// of dates and malformed texts, then random texts that are mostly well formed
// with random content, some corrupted, some of wrong length and some noise.
// The year bounds change between phases, with extremes and crossed bounds.
// The sender idles in bursts and the result side stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb;
    import dsv_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_CHARS  = 180;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [CHAR_W-1:0]    i_char_code;
    logic                 i_final_char;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [3:0]           o_status;
    logic [DAY_W-1:0]     o_day_value;
    logic [MONTH_W-1:0]   o_month_value;
    logic [YEAR_W-1:0]    o_year_value;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [YEAR_W-1:0]    i_cfg_data;

    int                   fail_count;
    int                   pending;
    int                   cycle_count = 0;
    int                   chars_sent = 0;
    int                   burst_left = 5;
    int                   stall_mode = 0;
    int                   stall_left = 0;
    logic [CHAR_W-1:0]    text_chars[$];

    string directed_texts [23] = '{
        "29/02/2000", "29/02/1900", "29/02/2024", "30/02/2024", "31/04/2021",
        "30/11/2021", "31/12/2099", "01/01/1900", "01/01/1899", "01/01/2100",
        "00/01/2000", "01/00/2000", "01/13/2000", "32/01/2000", "99/99/9999",
        "1a/01/2000", "01/0x/2000", "01/01/20y0", "01-01/2000", "01/01.2000",
        "01/01/200", "01/01/2000xyz", "7"
    };

    date_string_validator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_char_code   (i_char_code),
        .i_final_char  (i_final_char),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_day_value   (o_day_value),
        .o_month_value (o_month_value),
        .o_year_value  (o_year_value),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    dsv_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_char_code   (i_char_code),
        .i_final_char  (i_final_char),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_status      (o_status),
        .i_day_value   (o_day_value),
        .i_month_value (o_month_value),
        .i_year_value  (o_year_value),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 99) < 30);
            2: i_out_stall <= cycle_count[2];
            default: i_out_stall <= ($urandom_range(0, 99) < 75);
        endcase
    end

    task automatic put_char(input logic [CHAR_W-1:0] c, input logic fin);
        int gap;
        i_in_valid <= 1'b1;
        i_char_code <= c;
        i_final_char <= fin;
        do @(posedge i_clk); while (o_in_stall);
        chars_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(1, 10);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 20);
        end
    endtask

    task automatic send_text();
        for (int k = 0; k < text_chars.size(); k++) begin
            put_char(text_chars[k], k == text_chars.size() - 1);
        end
        text_chars.delete();
    endtask

    task automatic push_str(input string s);
        for (int k = 0; k < s.len(); k++) text_chars.push_back(s[k]);
    endtask

    task automatic push_num(input int v, input int digits);
        int div;
        div = 1;
        repeat (digits - 1) div *= 10;
        repeat (digits) begin
            text_chars.push_back(DIGIT_ZERO + CHAR_W'((v / div) % 10));
            div /= 10;
        end
    endtask

    task automatic make_random_text();
        int kind;
        int d;
        int m;
        int y;
        int n;
        int p;
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
            case ($urandom_range(0, 9))
                0: d = 0;
                1: d = $urandom_range(29, 31);
                2: d = $urandom_range(32, 99);
                default: d = $urandom_range(1, 31);
            endcase
            case ($urandom_range(0, 9))
                0: m = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 99);
                1, 2: m = 2;
                3: begin
                    p = $urandom_range(0, 3);
                    m = (p == 0) ? 4 : (p == 1) ? 6 : (p == 2) ? 9 : 11;
                end
                default: m = $urandom_range(1, 12);
            endcase
            case ($urandom_range(0, 5))
                0: y = $urandom_range(0, 9999);
                1: y = $urandom_range(0, 99) * 100;
                2: y = $urandom_range(475, 525) * 4;
                default: y = $urandom_range(1850, 2150);
            endcase
            push_num(d, 2);
            text_chars.push_back(SEP_CHAR);
            push_num(m, 2);
            text_chars.push_back(SEP_CHAR);
            push_num(y, 4);
            if (kind >= 60) begin
                p = $urandom_range(0, 9);
                text_chars[p] = CHAR_W'($urandom_range(0, 255));
            end
        end else if (kind < 90) begin
            n = $urandom_range(1, 15);
            repeat (n) begin
                p = $urandom_range(0, 10);
                if ($urandom_range(0, 1) == 0) begin
                    text_chars.push_back(CHAR_W'($urandom_range(0, 255)));
                end else begin
                    text_chars.push_back((p == 10) ? SEP_CHAR : DIGIT_ZERO + CHAR_W'(p));
                end
            end
        end else begin
            repeat (10) text_chars.push_back(CHAR_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [YEAR_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_bounds(input int lo, input int hi);
        write_reg(REG_EARLIEST_YEAR, YEAR_W'(lo));
        write_reg(REG_LATEST_YEAR, YEAR_W'(hi));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int goal);
        while (chars_sent < goal) begin
            make_random_text();
            send_text();
            if ($urandom_range(0, 39) == 0) wait_idle();
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_char_code <= '0;
        i_final_char <= 1'b0;
        i_out_stall <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        foreach (directed_texts[k]) begin
            push_str(directed_texts[k]);
            send_text();
        end
        push_str("0");
        text_chars.push_back(8'hFF);
        push_str("/12/2000");
        send_text();
        push_str("15/06/19");
        text_chars.push_back(8'h00);
        push_str("9");
        send_text();
        text_chars.push_back(8'hFF);
        send_text();
        run_random(PHASE_CHARS);

        set_bounds(0, 9999);
        push_str("29/02/0000");
        send_text();
        push_str("31/12/9999");
        send_text();
        run_random(2 * PHASE_CHARS);

        set_bounds(9999, 0);
        run_random(3 * PHASE_CHARS);

        set_bounds(2000, 2000);
        push_str("29/02/2000");
        send_text();
        run_random(4 * PHASE_CHARS);

        set_bounds(0, 0);
        run_random(5 * PHASE_CHARS);

        set_bounds($urandom_range(0, 9999), $urandom_range(0, 9999));
        run_random(6 * PHASE_CHARS);

        set_bounds($urandom_range(1000, 2000), $urandom_range(2000, 9999));
        run_random(7 * PHASE_CHARS);

        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
